// File: hdl/bilinear_image_scaler_defines.svh
// Assertion macros used by the checker file of the bilinear image scaler.
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/bis_pkg.sv
// Shared constants, codes and field widths of the bilinear image scaler.
package bis_pkg;

   localparam int DEFAULT_MAX_SOURCE_WIDTH  = 64;
   localparam int DEFAULT_MAX_SOURCE_HEIGHT = 64;
   localparam int DEFAULT_FRACTION_BITS     = 8;

   localparam int LOAD_INDEX_W  = 12;
   localparam int PIXEL_W       = 32;
   localparam int DEST_W        = 12;
   localparam int SOURCE_SIZE_W = 7;
   localparam int TARGET_SIZE_W = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int CHANNEL_W     = 8;
   localparam int CHANNELS      = 4;
   localparam int SIZE_RESET    = 64;

   typedef enum logic {
      MODE_LOAD   = 1'b0,
      MODE_SAMPLE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_TARGET_WIDTH  = 2'd2,
      CSR_TARGET_HEIGHT = 2'd3
   } csr_index_type;

endpackage

// File: hdl/bilinear_image_scaler.sv
// Top level of the bilinear image scaler: source store and sample pipeline.
// NUM_W = 13 + clog2(max side + 1) + FRACTION_BITS - 1 is the depth of the per-axis
// divider, which retires one quotient bit per stage.
// Throughput is one item per cycle; the whole pipeline holds only while a sample is stalled.
// Reset clears the valid bits and sets all four size registers to 64; the image is undefined.
module bilinear_image_scaler #(
   parameter int MAX_SOURCE_WIDTH  = bis_pkg::DEFAULT_MAX_SOURCE_WIDTH,
   parameter int MAX_SOURCE_HEIGHT = bis_pkg::DEFAULT_MAX_SOURCE_HEIGHT,
   parameter int FRACTION_BITS     = bis_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bis_pkg::mode_type                  req_mode,
   input  logic [bis_pkg::LOAD_INDEX_W-1:0]   req_load_index,
   input  logic [bis_pkg::PIXEL_W-1:0]        req_load_pixel,
   input  logic [bis_pkg::DEST_W-1:0]         req_dest_x,
   input  logic [bis_pkg::DEST_W-1:0]         req_dest_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bis_pkg::PIXEL_W-1:0]        rsp_sample_pixel,
   input  logic                               csr_write_en,
   input  bis_pkg::csr_index_type             csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import bis_pkg::*;

   localparam int MAX_SIDE  = (MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
                              MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
   localparam int SRC_W     = $clog2(MAX_SIDE + 1);
   localparam int IDX_W     = $clog2(MAX_SIDE);
   localparam int PROD_W    = DEST_W + 1 + SRC_W;
   localparam int NUM_W     = PROD_W + FRACTION_BITS - 1;
   localparam int RAW_W     = NUM_W - FRACTION_BITS;
   localparam int DEPTH     = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int WGT_W     = FRACTION_BITS + 1;
   localparam int FIX_ONE   = 1 << FRACTION_BITS;
   localparam int FIX_HALF  = 1 << (FRACTION_BITS - 1);
   localparam int TOP_W     = CHANNEL_W + FRACTION_BITS;
   localparam int ACC_W     = CHANNEL_W + 2 * FRACTION_BITS + 1;
   localparam int ROUND_ADD = 1 << (2 * FRACTION_BITS - 1);
   localparam logic [CHANNEL_W-1:0] CHANNEL_MAX = '1;

   typedef struct packed {
      mode_type                  mode;
      logic [LOAD_INDEX_W-1:0]   load_index;
      logic [PIXEL_W-1:0]        load_pixel;
   } side_type;

   typedef struct packed {
      logic [IDX_W-1:0] i0;
      logic [IDX_W-1:0] i1;
      logic [WGT_W-1:0] f;
   } axis_type;

   // Maps a quotient floor(((2d+1)*src*HALF)/dst) to neighbor indices and weight.
   function automatic axis_type map_axis(input logic [NUM_W-1:0] q,
                                         input logic [IDX_W-1:0] maxi);
      axis_type          r;
      logic [NUM_W-1:0]  s;
      logic [RAW_W-1:0]  raw;
      s   = q - NUM_W'(FIX_HALF);
      raw = s[NUM_W-1:FRACTION_BITS];
      if (q < NUM_W'(FIX_HALF)) begin
         r.i0 = '0;
         r.f  = '0;
      end else if (raw > RAW_W'(maxi)) begin
         // Past the last column or row the fraction always saturates to one.
         r.i0 = maxi;
         r.f  = WGT_W'(FIX_ONE);
      end else begin
         r.i0 = raw[IDX_W-1:0];
         r.f  = {1'b0, s[FRACTION_BITS-1:0]};
      end
      r.i1 = (r.i0 == maxi) ? maxi : r.i0 + 1'b1;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_SOURCE_WIDTH) + ADDR_W'(col));
   endfunction

   // Configuration registers.
   logic [SOURCE_SIZE_W-1:0] src_width_ff, src_height_ff;
   logic [TARGET_SIZE_W-1:0] tgt_width_ff, tgt_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SOURCE_SIZE_W'(SIZE_RESET);
         src_height_ff <= SOURCE_SIZE_W'(SIZE_RESET);
         tgt_width_ff  <= TARGET_SIZE_W'(SIZE_RESET);
         tgt_height_ff <= TARGET_SIZE_W'(SIZE_RESET);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  src_width_ff  <= csr_write_data[SOURCE_SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: src_height_ff <= csr_write_data[SOURCE_SIZE_W-1:0];
            CSR_TARGET_WIDTH:  tgt_width_ff  <= csr_write_data;
            CSR_TARGET_HEIGHT: tgt_height_ff <= csr_write_data;
         endcase
      end
   end

   logic [SRC_W-1:0]         src_w, src_h;
   logic [IDX_W-1:0]         max_x, max_y;
   logic [TARGET_SIZE_W-1:0] den_x, den_y;

   always_comb begin
      if (src_width_ff == '0) begin
         src_w = SRC_W'(1);
      end else if (32'(src_width_ff) > 32'(MAX_SOURCE_WIDTH)) begin
         src_w = SRC_W'(MAX_SOURCE_WIDTH);
      end else begin
         src_w = SRC_W'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         src_h = SRC_W'(1);
      end else if (32'(src_height_ff) > 32'(MAX_SOURCE_HEIGHT)) begin
         src_h = SRC_W'(MAX_SOURCE_HEIGHT);
      end else begin
         src_h = SRC_W'(src_height_ff);
      end
      max_x = IDX_W'(src_w - 1'b1);
      max_y = IDX_W'(src_h - 1'b1);
      den_x = (tgt_width_ff == '0) ? TARGET_SIZE_W'(1) : tgt_width_ff;
      den_y = (tgt_height_ff == '0) ? TARGET_SIZE_W'(1) : tgt_height_ff;
   end

   // The whole pipeline moves together unless the finished sample is held.
   logic rsp_valid_ff;
   logic advance;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Numerator stage.
   logic [PROD_W-1:0] prod_x, prod_y;
   logic [NUM_W-1:0]  num_x_in, num_y_in, num_x_ff, num_y_ff;
   side_type          side_m_in, side_m_ff;
   logic              v_m_ff;

   assign prod_x    = PROD_W'({req_dest_x, 1'b1}) * PROD_W'(src_w);
   assign prod_y    = PROD_W'({req_dest_y, 1'b1}) * PROD_W'(src_h);
   assign num_x_in  = NUM_W'(prod_x) << (FRACTION_BITS - 1);
   assign num_y_in  = NUM_W'(prod_y) << (FRACTION_BITS - 1);
   assign side_m_in = '{mode: req_mode, load_index: req_load_index,
                        load_pixel: req_load_pixel};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_m_ff <= 1'b0;
      end else if (advance) begin
         v_m_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_x_ff  <= num_x_in;
         num_y_ff  <= num_y_in;
         side_m_ff <= side_m_in;
      end
   end

   // Division stages, one per quotient bit, with the item's control alongside.
   logic [NUM_W-1:0] quo_x, quo_y;

   bis_div_pipe #(.NUM_W(NUM_W), .DEN_W(TARGET_SIZE_W)) u_bis_div_x (
      .clock  (clock),
      .enable (advance),
      .num    (num_x_ff),
      .den    (den_x),
      .quo    (quo_x)
   );

   bis_div_pipe #(.NUM_W(NUM_W), .DEN_W(TARGET_SIZE_W)) u_bis_div_y (
      .clock  (clock),
      .enable (advance),
      .num    (num_y_ff),
      .den    (den_y),
      .quo    (quo_y)
   );

   logic     v_d_ff    [NUM_W];
   side_type side_d_ff [NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_W; k++) begin
            v_d_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         v_d_ff[0] <= v_m_ff;
         for (int k = 1; k < NUM_W; k++) begin
            v_d_ff[k] <= v_d_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_d_ff[0] <= side_m_ff;
         for (int k = 1; k < NUM_W; k++) begin
            side_d_ff[k] <= side_d_ff[k-1];
         end
      end
   end

   // Mapping stage: neighbor indices and weights.
   axis_type axis_x_ff, axis_y_ff;
   side_type side_p1_ff;
   logic     v_p1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p1_ff <= 1'b0;
      end else if (advance) begin
         v_p1_ff <= v_d_ff[NUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         axis_x_ff  <= map_axis(quo_x, max_x);
         axis_y_ff  <= map_axis(quo_y, max_y);
         side_p1_ff <= side_d_ff[NUM_W-1];
      end
   end

   // Address stage.
   logic              we_p2_in, rd_p2_in;
   logic              we_p2_ff, rd_p2_ff;
   logic [ADDR_W-1:0] waddr_p2_ff;
   logic [PIXEL_W-1:0] wdata_p2_ff;
   logic [ADDR_W-1:0] addr00_p2_ff, addr01_p2_ff, addr10_p2_ff, addr11_p2_ff;
   logic [WGT_W-1:0]  fx_p2_ff, fy_p2_ff;

   assign we_p2_in = v_p1_ff && (side_p1_ff.mode == MODE_LOAD) &&
                     (32'(side_p1_ff.load_index) < 32'(DEPTH));
   assign rd_p2_in = v_p1_ff && (side_p1_ff.mode == MODE_SAMPLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         we_p2_ff <= 1'b0;
         rd_p2_ff <= 1'b0;
      end else if (advance) begin
         we_p2_ff <= we_p2_in;
         rd_p2_ff <= rd_p2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         waddr_p2_ff  <= ADDR_W'(side_p1_ff.load_index);
         wdata_p2_ff  <= side_p1_ff.load_pixel;
         addr00_p2_ff <= pix_addr(axis_y_ff.i0, axis_x_ff.i0);
         addr01_p2_ff <= pix_addr(axis_y_ff.i0, axis_x_ff.i1);
         addr10_p2_ff <= pix_addr(axis_y_ff.i1, axis_x_ff.i0);
         addr11_p2_ff <= pix_addr(axis_y_ff.i1, axis_x_ff.i1);
         fx_p2_ff     <= axis_x_ff.f;
         fy_p2_ff     <= axis_y_ff.f;
      end
   end

   // Source store: two copies written together, each read at two addresses.
   // Writes and reads sit in the same stage, so items see the store in order.
   logic [PIXEL_W-1:0] mem_top [DEPTH];
   logic [PIXEL_W-1:0] mem_bot [DEPTH];
   logic [PIXEL_W-1:0] px00_ff, px01_ff, px10_ff, px11_ff;
   logic               rd_p3_ff;
   logic [WGT_W-1:0]   fx_p3_ff, fy_p3_ff;

   always_ff @(posedge clock) begin
      if (advance && we_p2_ff) begin
         mem_top[waddr_p2_ff] <= wdata_p2_ff;
      end
      if (advance) begin
         px00_ff <= mem_top[addr00_p2_ff];
         px01_ff <= mem_top[addr01_p2_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (advance && we_p2_ff) begin
         mem_bot[waddr_p2_ff] <= wdata_p2_ff;
      end
      if (advance) begin
         px10_ff <= mem_bot[addr10_p2_ff];
         px11_ff <= mem_bot[addr11_p2_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_p3_ff <= 1'b0;
      end else if (advance) begin
         rd_p3_ff <= rd_p2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fx_p3_ff <= fx_p2_ff;
         fy_p3_ff <= fy_p2_ff;
      end
   end

   // Horizontal blend stage.
   logic [TOP_W-1:0] top_in [CHANNELS];
   logic [TOP_W-1:0] bot_in [CHANNELS];
   logic [TOP_W-1:0] top_ff [CHANNELS];
   logic [TOP_W-1:0] bot_ff [CHANNELS];
   logic             rd_p4_ff;
   logic [WGT_W-1:0] fy_p4_ff;

   always_comb begin
      logic [WGT_W-1:0] wx0;
      logic [TOP_W:0]   sum_top;
      logic [TOP_W:0]   sum_bot;
      wx0 = WGT_W'(FIX_ONE) - fx_p3_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         sum_top = (TOP_W+1)'(px00_ff[c*CHANNEL_W +: CHANNEL_W]) * (TOP_W+1)'(wx0) +
                   (TOP_W+1)'(px01_ff[c*CHANNEL_W +: CHANNEL_W]) * (TOP_W+1)'(fx_p3_ff);
         sum_bot = (TOP_W+1)'(px10_ff[c*CHANNEL_W +: CHANNEL_W]) * (TOP_W+1)'(wx0) +
                   (TOP_W+1)'(px11_ff[c*CHANNEL_W +: CHANNEL_W]) * (TOP_W+1)'(fx_p3_ff);
         top_in[c] = sum_top[TOP_W-1:0];
         bot_in[c] = sum_bot[TOP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_p4_ff <= 1'b0;
      end else if (advance) begin
         rd_p4_ff <= rd_p3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         top_ff   <= top_in;
         bot_ff   <= bot_in;
         fy_p4_ff <= fy_p3_ff;
      end
   end

   // Vertical blend, rounding and output register.
   logic [PIXEL_W-1:0] pixel_in, rsp_sample_pixel_ff;

   always_comb begin
      logic [WGT_W-1:0]     wy0;
      logic [ACC_W-1:0]     acc;
      logic [CHANNEL_W:0]   rounded;
      wy0 = WGT_W'(FIX_ONE) - fy_p4_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         acc = ACC_W'(top_ff[c]) * ACC_W'(wy0) + ACC_W'(bot_ff[c]) * ACC_W'(fy_p4_ff) +
               ACC_W'(ROUND_ADD);
         rounded = acc[ACC_W-1:2*FRACTION_BITS];
         pixel_in[c*CHANNEL_W +: CHANNEL_W] =
            (rounded > {1'b0, CHANNEL_MAX}) ? CHANNEL_MAX : rounded[CHANNEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rd_p4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rd_p4_ff) begin
         rsp_sample_pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_pixel = rsp_sample_pixel_ff;

endmodule

// File: hdl/bis_div_pipe.sv
// Pipelined restoring divider that retires one quotient bit per register stage.
module bis_div_pipe #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   // Each stage holds the partial remainder and a word that shifts the
   // remaining numerator bits out at the top and the quotient bits in at the bottom.
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_step
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] nq_prev;
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] nq_in;

      if (g == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign nq_prev  = nq_ff[g-1];
      end

      always_comb begin
         trial = {rem_prev, nq_prev[NUM_W-1]};
         if (trial >= {1'b0, den}) begin
            rem_in = DEN_W'(trial - {1'b0, den});
            nq_in  = {nq_prev[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            nq_in  = {nq_prev[NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g] <= rem_in;
            nq_ff[g]  <= nq_in;
         end
      end
   end

   assign quo = nq_ff[NUM_W-1];

endmodule

// File: hdl/bis_checker.sv
// Port-level checker for the bilinear image scaler and its bind statement.
`include "bilinear_image_scaler_defines.svh"

module bis_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [bis_pkg::PIXEL_W-1:0] rsp_sample_pixel
);
   import bis_pkg::*;

   // A held sample keeps its valid and its value.
   `BIS_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid, "sample dropped while stalled")
   `BIS_ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_sample_pixel), "sample changed while stalled")

   // The input side only waits while a finished sample is held at the output.
   `BIS_ASSERT_NOW(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without a held sample")

   // Nothing is presented in the cycle that follows reset.
   `BIS_ASSERT_NOW(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "sample presented right after reset")

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sample_pixel (rsp_sample_pixel)
);

// File: sim/tb.sv
// Testbench for the bilinear image scaler: directed table, then random phases of loads and samples.
`timescale 1ns / 100ps
module tb;
   import bis_pkg::*;

   localparam int FRAC = DEFAULT_FRACTION_BITS;
   localparam longint unsigned ONE = 64'd1 << FRAC;
   localparam longint unsigned HALF = ONE / 2;
   localparam int MAX_W = DEFAULT_MAX_SOURCE_WIDTH;
   localparam int MAX_H = DEFAULT_MAX_SOURCE_HEIGHT;
   localparam int DEPTH = MAX_W * MAX_H;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 300000;
   localparam int IDLE_PERCENT = 17;
   localparam int ITEMS_PER_PHASE = 48;

   typedef struct packed {
      bit                      is_config;
      logic [CSR_DATA_W-1:0]   src_w;
      logic [CSR_DATA_W-1:0]   src_h;
      logic [CSR_DATA_W-1:0]   dst_w;
      logic [CSR_DATA_W-1:0]   dst_h;
      mode_type                mode;
      logic [LOAD_INDEX_W-1:0] index;
      logic [PIXEL_W-1:0]      pixel;
      logic [DEST_W-1:0]       dx;
      logic [DEST_W-1:0]       dy;
      bit                      typed;
      logic [PIXEL_W-1:0]      typed_pixel;
   } script_row_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   mode_type                req_mode = MODE_LOAD;
   logic [LOAD_INDEX_W-1:0] req_load_index = '0;
   logic [PIXEL_W-1:0]      req_load_pixel = '0;
   logic [DEST_W-1:0]       req_dest_x = '0;
   logic [DEST_W-1:0]       req_dest_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]      rsp_sample_pixel;
   logic                    csr_write_en = 1'b0;
   csr_index_type           csr_index = CSR_SOURCE_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   // Predictor copy of the store and the size registers.
   logic [PIXEL_W-1:0]       source_copy [DEPTH];
   bit                       pixel_loaded [DEPTH];
   logic [SOURCE_SIZE_W-1:0] src_w_reg = SOURCE_SIZE_W'(SIZE_RESET);
   logic [SOURCE_SIZE_W-1:0] src_h_reg = SOURCE_SIZE_W'(SIZE_RESET);
   logic [TARGET_SIZE_W-1:0] dst_w_reg = TARGET_SIZE_W'(SIZE_RESET);
   logic [TARGET_SIZE_W-1:0] dst_h_reg = TARGET_SIZE_W'(SIZE_RESET);

   logic [PIXEL_W-1:0] pending_samples [$];
   logic [PIXEL_W-1:0] sample_due;
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 items_sent = 0;
   bit                 quiet_stretch = 1'b0;

   bilinear_image_scaler u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_load_index   (req_load_index),
      .req_load_pixel   (req_load_pixel),
      .req_dest_x       (req_dest_x),
      .req_dest_y       (req_dest_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_pixel (rsp_sample_pixel),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned source_extent(input logic [SOURCE_SIZE_W-1:0] v,
                                                 input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic int unsigned target_extent(input logic [TARGET_SIZE_W-1:0] v);
      return (v == 0) ? 1 : v;
   endfunction

   // Maps a destination coordinate back to the two source neighbours and the weight.
   function automatic void map_axis(input logic [DEST_W-1:0] d, input int unsigned src,
                                    input int unsigned dst, output int unsigned lo,
                                    output int unsigned hi, output int unsigned frac);
      longint unsigned q, s, idx, f;
      q = (2 * longint'(d) + 1) * src * HALF / dst;
      if (q < HALF) begin
         lo = 0;
         frac = 0;
      end else begin
         s = q - HALF;
         idx = s >> FRAC;
         if (idx > src - 1) idx = src - 1;
         f = s - (idx << FRAC);
         if (f > ONE) f = ONE;
         lo = 32'(idx);
         frac = 32'(f);
      end
      hi = (lo + 1 > src - 1) ? src - 1 : lo + 1;
   endfunction

   function automatic logic [PIXEL_W-1:0] scaled_pixel(input logic [DEST_W-1:0] dx,
                                                       input logic [DEST_W-1:0] dy);
      int unsigned        sw, sh, x0, x1, y0, y1, fx, fy;
      logic [PIXEL_W-1:0] p00, p01, p10, p11, result;
      longint unsigned    a, b, c, d, top, bottom, v;
      sw = source_extent(src_w_reg, MAX_W);
      sh = source_extent(src_h_reg, MAX_H);
      map_axis(dx, sw, target_extent(dst_w_reg), x0, x1, fx);
      map_axis(dy, sh, target_extent(dst_h_reg), y0, y1, fy);
      p00 = source_copy[y0 * MAX_W + x0];
      p01 = source_copy[y0 * MAX_W + x1];
      p10 = source_copy[y1 * MAX_W + x0];
      p11 = source_copy[y1 * MAX_W + x1];
      result = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         a = p00[ch*CHANNEL_W +: CHANNEL_W];
         b = p01[ch*CHANNEL_W +: CHANNEL_W];
         c = p10[ch*CHANNEL_W +: CHANNEL_W];
         d = p11[ch*CHANNEL_W +: CHANNEL_W];
         top = a * (ONE - fx) + b * fx;
         bottom = c * (ONE - fx) + d * fx;
         v = top * (ONE - fy) + bottom * fy;
         v = (v + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
         if (v > 255) v = 255;
         result[ch*CHANNEL_W +: CHANNEL_W] = v[CHANNEL_W-1:0];
      end
      return result;
   endfunction

   // Presents one item, waits for its acceptance and records its effect.
   task automatic drive_item(input mode_type m, input logic [LOAD_INDEX_W-1:0] index,
                             input logic [PIXEL_W-1:0] pixel, input logic [DEST_W-1:0] dx,
                             input logic [DEST_W-1:0] dy, input bit typed,
                             input logic [PIXEL_W-1:0] typed_pixel);
      while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_load_index <= index;
      req_load_pixel <= pixel;
      req_dest_x <= dx;
      req_dest_y <= dy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (m == MODE_LOAD) begin
         source_copy[index] = pixel;
         pixel_loaded[index] = 1'b1;
      end else begin
         pending_samples.push_back(typed ? typed_pixel : scaled_pixel(dx, dy));
      end
   endtask

   task automatic load_pixel(input logic [LOAD_INDEX_W-1:0] index,
                             input logic [PIXEL_W-1:0] pixel);
      drive_item(MODE_LOAD, index, pixel, DEST_W'($urandom), DEST_W'($urandom), 1'b0, '0);
   endtask

   task automatic request_sample(input logic [DEST_W-1:0] dx, input logic [DEST_W-1:0] dy);
      drive_item(MODE_SAMPLE, LOAD_INDEX_W'($urandom), $urandom, dx, dy, 1'b0, '0);
   endtask

   // Waits until every sample is back and trailing loads have left the pipeline.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sizes(input logic [CSR_DATA_W-1:0] sw, input logic [CSR_DATA_W-1:0] sh,
                              input logic [CSR_DATA_W-1:0] tw, input logic [CSR_DATA_W-1:0] th);
      settle();
      csr_write_en <= 1'b1;
      csr_index <= CSR_SOURCE_WIDTH;
      csr_write_data <= sw;
      @(posedge clock);
      csr_index <= CSR_SOURCE_HEIGHT;
      csr_write_data <= sh;
      @(posedge clock);
      csr_index <= CSR_TARGET_WIDTH;
      csr_write_data <= tw;
      @(posedge clock);
      csr_index <= CSR_TARGET_HEIGHT;
      csr_write_data <= th;
      @(posedge clock);
      csr_write_en <= 1'b0;
      src_w_reg = sw[SOURCE_SIZE_W-1:0];
      src_h_reg = sh[SOURCE_SIZE_W-1:0];
      dst_w_reg = tw[TARGET_SIZE_W-1:0];
      dst_h_reg = th[TARGET_SIZE_W-1:0];
   endtask

   // Loads every still unwritten pixel that the coming sample reads.
   task automatic fill_neighbors(input logic [DEST_W-1:0] dx, input logic [DEST_W-1:0] dy);
      int unsigned x0, x1, y0, y1, fx, fy;
      int unsigned spot [4];
      map_axis(dx, source_extent(src_w_reg, MAX_W), target_extent(dst_w_reg), x0, x1, fx);
      map_axis(dy, source_extent(src_h_reg, MAX_H), target_extent(dst_h_reg), y0, y1, fy);
      spot = '{y0 * MAX_W + x0, y0 * MAX_W + x1, y1 * MAX_W + x0, y1 * MAX_W + x1};
      foreach (spot[k])
         if (!pixel_loaded[spot[k]]) load_pixel(LOAD_INDEX_W'(spot[k]), $urandom);
   endtask

   task automatic random_traffic(input int count);
      int unsigned       sw, sh, tw, th, pick;
      int                stop_at;
      logic [DEST_W-1:0] dx, dy;
      sw = source_extent(src_w_reg, MAX_W);
      sh = source_extent(src_h_reg, MAX_H);
      tw = target_extent(dst_w_reg);
      th = target_extent(dst_h_reg);
      if (tw > 4096) tw = 4096;
      if (th > 4096) th = 4096;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // Most samples fall inside the rectangle, a few anywhere in the field range.
            if ($urandom_range(0, 9) == 0) begin
               dx = DEST_W'($urandom);
               dy = DEST_W'($urandom);
            end else begin
               dx = DEST_W'($urandom_range(0, tw - 1));
               dy = DEST_W'($urandom_range(0, th - 1));
            end
            fill_neighbors(dx, dy);
            request_sample(dx, dy);
         end else if (pick < 90) begin
            load_pixel(LOAD_INDEX_W'($urandom_range(0, sh - 1) * MAX_W
                                     + $urandom_range(0, sw - 1)), $urandom);
         end else begin
            load_pixel(LOAD_INDEX_W'($urandom), $urandom);
         end
      end
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] sw, input logic [CSR_DATA_W-1:0] sh,
                            input logic [CSR_DATA_W-1:0] tw, input logic [CSR_DATA_W-1:0] th);
      write_sizes(sw, sh, tw, th);
      random_traffic(ITEMS_PER_PHASE);
   endtask

   function automatic script_row_type load_row(input logic [LOAD_INDEX_W-1:0] index,
                                               input logic [PIXEL_W-1:0] pixel);
      script_row_type row;
      row = '0;
      row.mode = MODE_LOAD;
      row.index = index;
      row.pixel = pixel;
      row.dx = '1;
      row.dy = '1;
      return row;
   endfunction

   function automatic script_row_type sample_row(input logic [DEST_W-1:0] dx,
                                                 input logic [DEST_W-1:0] dy);
      script_row_type row;
      row = '0;
      row.mode = MODE_SAMPLE;
      row.index = '1;
      row.pixel = '1;
      row.dx = dx;
      row.dy = dy;
      return row;
   endfunction

   function automatic script_row_type known_row(input logic [DEST_W-1:0] dx,
                                                input logic [DEST_W-1:0] dy,
                                                input logic [PIXEL_W-1:0] pixel);
      script_row_type row;
      row = sample_row(dx, dy);
      row.typed = 1'b1;
      row.typed_pixel = pixel;
      return row;
   endfunction

   function automatic script_row_type sizes_row(input logic [CSR_DATA_W-1:0] sw,
                                                input logic [CSR_DATA_W-1:0] sh,
                                                input logic [CSR_DATA_W-1:0] tw,
                                                input logic [CSR_DATA_W-1:0] th);
      script_row_type row;
      row = '0;
      row.is_config = 1'b1;
      row.src_w = sw;
      row.src_h = sh;
      row.dst_w = tw;
      row.dst_h = th;
      return row;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               $error("sample_pixel: expected none, got %h", rsp_sample_pixel);
               mismatch_count++;
            end else begin
               sample_due = pending_samples.pop_front();
               if (rsp_sample_pixel !== sample_due) begin
                  $error("sample_pixel: expected %h, got %h", sample_due, rsp_sample_pixel);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= !quiet_stretch && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   initial begin
      script_row_type script [$];
      // Rows at the reset sizes read only the pixels loaded just before them.
      script = '{
         load_row(0, 32'hFFFF_FFFF),
         load_row(1, 32'h0000_0000),
         load_row(64, 32'h1234_5678),
         load_row(65, 32'h80FF_0180),
         load_row(63, 32'h00FF_00FF),
         load_row(127, 32'hFF00_FF00),
         load_row(4095, 32'hA5C3_3C5A),
         known_row(0, 0, 32'hFFFF_FFFF),
         known_row(63, 63, 32'hA5C3_3C5A),
         known_row(4095, 4095, 32'hA5C3_3C5A),
         known_row(4095, 0, 32'h00FF_00FF),
         load_row(0, 32'h0102_0304),
         known_row(0, 0, 32'h0102_0304),
         sizes_row(2, 2, 4, 4),
         known_row(0, 0, 32'h0102_0304),
         known_row(3, 3, 32'h80FF_0180),
         sample_row(1, 1),
         sample_row(2, 1),
         sizes_row(0, 2, 0, 8191),
         sample_row(0, 4095),
         known_row(4095, 0, 32'h0102_0304),
         sample_row(1000, 17)
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_config)
            write_sizes(script[i].src_w, script[i].src_h, script[i].dst_w, script[i].dst_h);
         else
            drive_item(script[i].mode, script[i].index, script[i].pixel, script[i].dx,
                       script[i].dy, script[i].typed, script[i].typed_pixel);
      end

      run_phase(4, 3, 9, 7);
      run_phase(1, 1, 1, 1);
      run_phase(0, 0, 0, 0);
      // The two large-image phases run with neither side idling.
      quiet_stretch = 1'b1;
      run_phase(64, 64, 4096, 4096);
      run_phase(127, 100, 13, 5);
      quiet_stretch = 1'b0;
      run_phase(8, 16, 8, 16);
      run_phase(37, 2, 3, 8191);
      repeat (2)
         run_phase(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                   CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));

      settle();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
